// ===== hdl/u8seg_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and byte classification for the utf-8 segmenter
// no dependencies

package u8seg_pkg;

  localparam int unsigned MAX_RESULTS = 3;

  // lead byte tags, compared against the top bits of a byte
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [2:0] LEAD2_TAG   = 3'h6;
  localparam logic [3:0] LEAD3_TAG   = 4'hE;
  localparam logic [4:0] LEAD4_TAG   = 5'h1E;

  localparam logic [2:0] LEN_ONE   = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  // one result transaction
  typedef struct packed {
    logic [31:0] chr_bytes;
    logic [2:0]  chr_len;
    logic        word;
    logic        tok_begin;
    logic        run_last;
    logic        text_last;
  } char_t;

  // bytes in a character from its lead byte, invalid leads count as one
  function automatic logic [2:0] lead_class(input logic [7:0] b);
    logic [2:0] len;
    if (b < ASCII_LIMIT) begin
      len = LEN_ONE;
    end else if (b[7:5] == LEAD2_TAG) begin
      len = LEN_TWO;
    end else if (b[7:4] == LEAD3_TAG) begin
      len = LEN_THREE;
    end else if (b[7:3] == LEAD4_TAG) begin
      len = LEN_FOUR;
    end else begin
      len = LEN_ONE;
    end
    return len;
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

endpackage

// ===== hdl/utf8_char_and_word_segmenter.sv =====
`timescale 1ns / 1ps
// utf-8 character and word segmenter top level: handshakes, config, result queue
// depends on u8seg_pkg and u8seg_core
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-----------------------------------
//  input    | in        | in_valid_i / in_stall_o | text_byte_i, end_of_text_i
//  output   | out       | out_valid_o/out_stall_i | char_bytes_o, char_length_o,
//           |           |                         | word_char_o, token_begins_o,
//           |           |                         | run_last_o, text_last_o
//  config   | in        | cfg_we_i                | cfg_wdata_i (word_mode)
//
//  one byte per cycle unless stalled; each byte's results appear in the cycle after it
//  a final byte inside an unfinished character yields up to three results, which drain
//  through the result queue one per cycle while out_stall_i is low and input is stalled
//  in_stall_o rises only while more than one result is queued, or one is queued
//  and the output is stalled
//  reset empties the queue, clears held state and sets word_mode to 1

module utf8_char_and_word_segmenter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] char_bytes_o,
  output logic [2:0]  char_length_o,
  output logic        word_char_o,
  output logic        token_begins_o,
  output logic        run_last_o,
  output logic        text_last_o,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);
  import u8seg_pkg::*;

  logic word_mode_q;

  // results of the current byte, formed combinationally from input and held state
  char_t [MAX_RESULTS-1:0] res;
  logic [1:0]              res_cnt;

  // result queue, head at entry 0, shifts on each output transaction
  char_t [MAX_RESULTS-1:0] buf_q, buf_d;
  logic [1:0]              buf_cnt_q, buf_cnt_d;

  logic in_acc, out_acc;

  // accept when the queue is empty, or its last entry leaves at this edge
  assign in_stall_o  = (buf_cnt_q > 2'd1) || ((buf_cnt_q == 2'd1) && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (buf_cnt_q != 2'd0);
  assign out_acc     = out_valid_o && !out_stall_i;

  u8seg_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_acc),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .word_mode_i   (word_mode_q),
    .res_o         (res),
    .res_cnt_o     (res_cnt)
  );

  always_comb begin
    buf_d     = buf_q;
    buf_cnt_d = buf_cnt_q;
    if (in_acc) begin
      // queue is empty or drains now, so the new results replace it
      buf_d     = res;
      buf_cnt_d = res_cnt;
    end else if (out_acc) begin
      buf_d[0]  = buf_q[1];
      buf_d[1]  = buf_q[2];
      buf_cnt_d = buf_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_cnt_q   <= 2'd0;
      word_mode_q <= 1'b1;
    end else begin
      buf_cnt_q <= buf_cnt_d;
      if (cfg_we_i) begin
        word_mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  assign char_bytes_o   = buf_q[0].chr_bytes;
  assign char_length_o  = buf_q[0].chr_len;
  assign word_char_o    = buf_q[0].word;
  assign token_begins_o = buf_q[0].tok_begin;
  assign run_last_o     = buf_q[0].run_last;
  assign text_last_o    = buf_q[0].text_last;

  // a result that is not the byte's last has its followers already queued
  a_run_has_followers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !run_last_o) |-> (buf_cnt_q > 2'd1))
    else $error("non-final result without queued followers");

  a_text_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && text_last_o) |-> run_last_o)
    else $error("end of text flagged on a result that is not the last of its byte");

  a_final_byte_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_of_text_i) |=> out_valid_o)
    else $error("final byte left no result at the output");

endmodule

// ===== hdl/u8seg_core.sv =====
`timescale 1ns / 1ps
// character assembly state and result formation for one accepted byte
// depends on u8seg_pkg

module u8seg_core (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          accept_i,
  input  logic [7:0]                                    text_byte_i,
  input  logic                                          end_of_text_i,
  input  logic                                          word_mode_i,
  output u8seg_pkg::char_t [u8seg_pkg::MAX_RESULTS-1:0] res_o,
  output logic [1:0]                                    res_cnt_o
);
  import u8seg_pkg::*;

  logic [7:0] held_q [3];
  logic [1:0] cnt_q, cnt_d;
  logic [2:0] need_q, need_d;
  logic       prev_q, prev_d;

  logic [2:0] cls_in, cls_e1, cnt_inc;
  logic       start_held, emit_now, pair, flush;
  logic [1:0] hc_post;
  logic [7:0] e0, e1, e2;
  logic [7:0] nb1, nb2, nb3;
  logic [2:0] held_wr;
  logic [2:0] w, pw;

  always_comb begin
    cls_in     = lead_class(text_byte_i);
    cnt_inc    = {1'b0, cnt_q} + 3'd1;
    start_held = (cnt_q == 2'd0) && (cls_in != LEN_ONE);
    // complete character: a single-byte lead, or the last byte of a held one
    emit_now   = (cnt_q == 2'd0) ? (cls_in == LEN_ONE) : (cnt_inc >= need_q);

    // held bytes as they stand after this byte
    e0 = (cnt_q == 2'd0) ? text_byte_i : held_q[0];
    e1 = (cnt_q == 2'd1) ? text_byte_i : held_q[1];
    e2 = (cnt_q == 2'd2) ? text_byte_i : held_q[2];
    if (emit_now) begin
      hc_post = 2'd0;
    end else if (cnt_q == 2'd0) begin
      hc_post = 2'd1;
    end else begin
      hc_post = cnt_inc[1:0];
    end

    flush  = end_of_text_i && (hc_post != 2'd0);
    cls_e1 = lead_class(e1);
    pair   = (hc_post == 2'd3) && (cls_e1 == LEN_TWO);

    // bytes of a completed multibyte character
    nb1 = (cnt_q > 2'd1) ? held_q[1] : text_byte_i;
    nb2 = (need_q > LEN_TWO) ? ((cnt_q > 2'd2) ? held_q[2] : text_byte_i) : 8'h00;
    nb3 = (need_q > LEN_THREE) ? text_byte_i : 8'h00;

    res_o = '0;
    if (emit_now && (cnt_q == 2'd0)) begin
      res_o[0].chr_bytes = {24'h0, text_byte_i};
      res_o[0].chr_len   = LEN_ONE;
    end else if (emit_now) begin
      res_o[0].chr_bytes = {nb3, nb2, nb1, held_q[0]};
      res_o[0].chr_len   = need_q;
    end else begin
      res_o[0].chr_bytes = {24'h0, e0};
      res_o[0].chr_len   = LEN_ONE;
    end
    if (pair) begin
      res_o[1].chr_bytes = {16'h0, e2, e1};
      res_o[1].chr_len   = LEN_TWO;
    end else begin
      res_o[1].chr_bytes = {24'h0, e1};
      res_o[1].chr_len   = LEN_ONE;
    end
    res_o[2].chr_bytes = {24'h0, e2};
    res_o[2].chr_len   = LEN_ONE;

    if (emit_now) begin
      res_cnt_o = 2'd1;
    end else if (flush) begin
      if (hc_post == 2'd3) begin
        res_cnt_o = pair ? 2'd2 : 2'd3;
      end else begin
        res_cnt_o = hc_post;
      end
    end else begin
      res_cnt_o = 2'd0;
    end

    // word flags chain from one result to the next
    for (int k = 0; k < MAX_RESULTS; k++) begin
      w[k] = (res_o[k].chr_len > LEN_ONE) || is_letter(res_o[k].chr_bytes[7:0]);
    end
    pw = {w[1], w[0], prev_q};
    for (int k = 0; k < MAX_RESULTS; k++) begin
      res_o[k].word      = w[k];
      res_o[k].tok_begin = !(word_mode_i && w[k] && pw[k]);
      res_o[k].run_last  = (res_cnt_o == 2'(k + 1));
      res_o[k].text_last = (res_cnt_o == 2'(k + 1)) && end_of_text_i;
    end

    held_wr    = '0;
    held_wr[0] = start_held;
    held_wr[1] = (cnt_q == 2'd1) && !emit_now;
    held_wr[2] = (cnt_q == 2'd2) && !emit_now;

    if (end_of_text_i) begin
      cnt_d  = 2'd0;
      need_d = 3'd0;
      prev_d = 1'b0;
    end else begin
      cnt_d  = hc_post;
      need_d = emit_now ? 3'd0 : (start_held ? cls_in : need_q);
      prev_d = emit_now ? w[0] : prev_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      need_q <= 3'd0;
      prev_q <= 1'b0;
    end else if (accept_i) begin
      cnt_q  <= cnt_d;
      need_q <= need_d;
      prev_q <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (accept_i && held_wr[k]) begin
        held_q[k] <= text_byte_i;
      end
    end
  end

  a_held_below_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd0) |-> (need_q > {1'b0, cnt_q}))
    else $error("held byte count not below needed length");

  a_idle_no_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> (need_q == 3'd0))
    else $error("needed length set with nothing held");

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && end_of_text_i) |-> (res_cnt_o != 2'd0))
    else $error("final byte produced no character");

endmodule

// ===== verif/utf8_char_and_word_segmenter_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for utf8_char_and_word_segmenter: random byte texts in and
// predicted character transactions compared field by field; depends on u8seg_pkg

module utf8_char_and_word_segmenter_test;

  import u8seg_pkg::char_t;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned MAX_WAIT     = 19;    // longest idle drawn per transaction
  localparam int unsigned SETTLE       = 4;     // cycles for a silent byte to finish
  localparam int unsigned HOLD_AT      = 60;    // result count that starts the long hold-off
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned QUIET_LIMIT  = 3000;  // cycles without any transaction

  // one input transaction
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } text_item_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [7:0]  text_byte_i    = 8'h00;
  logic        end_of_text_i  = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [31:0] char_bytes_o;
  logic [2:0]  char_length_o;
  logic        word_char_o;
  logic        token_begins_o;
  logic        run_last_o;
  logic        text_last_o;
  logic        cfg_we_i       = 1'b0;
  logic        cfg_wdata_i    = 1'b0;

  utf8_char_and_word_segmenter DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .char_bytes_o   (char_bytes_o),
    .char_length_o  (char_length_o),
    .word_char_o    (word_char_o),
    .token_begins_o (token_begins_o),
    .run_last_o     (run_last_o),
    .text_last_o    (text_last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  text_item_t  byte_feed[$];    // bytes waiting to be offered
  char_t       char_expect[$];  // predicted characters not yet seen at the output
  char_t       step_chars[$];   // characters caused by the byte being segmented
  bit          failed = 1'b0;

  // shadow of the segmenter state
  logic [7:0]  pend_bytes[4];
  int unsigned pend_count = 0;
  int unsigned pend_need  = 0;
  logic        prev_word  = 1'b0;
  logic        mode_word  = 1'b1;   // word_mode after reset

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // character length announced by a lead byte, anything malformed is one byte
  function automatic int unsigned lead_len(input logic [7:0] b);
    casez (b)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 1;
    endcase
  endfunction

  // held bytes from index first on, first byte in the low lane
  function automatic logic [31:0] pack_held(input int unsigned first, input int unsigned len);
    logic [31:0] packed_word;
    packed_word = '0;
    for (int k = 0; k < len && k < 4; k++) packed_word[8*k +: 8] = pend_bytes[first + k];
    return packed_word;
  endfunction

  // one finished character: word flag, token start, then the word history moves on
  function automatic void add_char(input logic [31:0] bytes, input int unsigned len);
    char_t c;
    logic  w;
    w = (len > 1) || ((bytes[7:0] >= 8'h41) && (bytes[7:0] <= 8'h5A))
                  || ((bytes[7:0] >= 8'h61) && (bytes[7:0] <= 8'h7A));
    c.chr_bytes = bytes;
    c.chr_len   = len[2:0];
    c.word      = w;
    c.tok_begin = !(mode_word && w && prev_word);
    c.run_last  = 1'b0;
    c.text_last = 1'b0;
    prev_word   = w;
    step_chars.insert(step_chars.size(), c);
  endfunction

  // segment one accepted byte and queue the characters it finishes
  function automatic void segment_byte(input logic [7:0] b, input logic eot);
    int unsigned len;
    int unsigned cnt;
    int unsigned pos;
    char_t       tail;
    step_chars.delete();
    if (pend_count == 0) begin
      len = lead_len(b);
      if (len == 1) begin
        add_char({24'h0, b}, 1);
      end else begin
        pend_bytes[0] = b;
        pend_count    = 1;
        pend_need     = len;
      end
    end else begin
      pend_bytes[pend_count & 3] = b;
      pend_count++;
      if (pend_count >= pend_need || pend_count > 3) begin
        add_char(pack_held(0, pend_need), pend_need);
        pend_count = 0;
        pend_need  = 0;
      end
    end
    // text cut inside a character: the lead stands alone, the rest is split again
    if (eot) begin
      if (pend_count > 0) begin
        cnt = (pend_count > 3) ? 3 : pend_count;
        add_char(pack_held(0, 1), 1);
        pos = 1;
        while (pos < cnt) begin
          len = lead_len(pend_bytes[pos]);
          if (pos + len > cnt) len = 1;
          add_char(pack_held(pos, len), len);
          pos += len;
        end
      end
      pend_count = 0;
      pend_need  = 0;
      prev_word  = 1'b0;
    end
    if (step_chars.size() > 0) begin
      tail = step_chars.pop_back();
      tail.run_last  = 1'b1;
      tail.text_last = eot;
      step_chars.insert(step_chars.size(), tail);
    end
    foreach (step_chars[k]) char_expect.insert(char_expect.size(), step_chars[k]);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued bytes, random gaps between transactions
  // ---------------------------------------------------------------------------

  int unsigned send_wait    = 0;
  bit          send_idle_on = 1'b1;
  text_item_t  send_next;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        segment_byte(text_byte_i, end_of_text_i);
        send_wait = send_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if ($urandom_range(0, 29) == 0) send_idle_on = !send_idle_on;
      end
      if (in_valid_i && in_stall_o) begin
        // stalled: payload and valid stay put
      end else if (send_wait > 0) begin
        send_wait--;
        in_valid_i <= 1'b0;
      end else if (byte_feed.size() > 0) begin
        send_next = byte_feed.pop_front();
        text_byte_i   <= send_next.value;
        end_of_text_i <= send_next.last;
        in_valid_i    <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result transaction, random stalls plus one long hold-off
  // ---------------------------------------------------------------------------

  int unsigned recv_wait    = 0;
  int unsigned results_seen = 0;
  bit          recv_idle_on = 1'b1;
  char_t       want;

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (char_expect.size() == 0) begin
          $display("%0t: unexpected result, expected none actual char_bytes %h length %0d",
                   $time, char_bytes_o, char_length_o);
          failed = 1'b1;
        end else begin
          want = char_expect.pop_front();
          check_field("char_bytes",   want.chr_bytes,      char_bytes_o);
          check_field("char_length",  32'(want.chr_len),   32'(char_length_o));
          check_field("word_char",    32'(want.word),      32'(word_char_o));
          check_field("token_begins", 32'(want.tok_begin), 32'(token_begins_o));
          check_field("run_last",     32'(want.run_last),  32'(run_last_o));
          check_field("text_last",    32'(want.text_last), 32'(text_last_o));
        end
        results_seen++;
        recv_wait = recv_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if ($urandom_range(0, 29) == 0) recv_idle_on = !recv_idle_on;
        // long hold-off so the result queue fills and the input side stalls
        if (results_seen == HOLD_AT) recv_wait = HOLD_CYCLES;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends a run that stops moving
  // ---------------------------------------------------------------------------

  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic push_byte(input logic [7:0] value, input logic last);
    text_item_t item;
    item.value = value;
    item.last  = last;
    byte_feed.insert(byte_feed.size(), item);
  endtask

  // continuation byte, now and then an arbitrary one since they go unchecked
  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  function automatic logic [7:0] lead_byte(input int unsigned len);
    case (len)
      2:       return {3'b110,   5'($urandom_range(0, 31))};
      3:       return {4'b1110,  4'($urandom_range(0, 15))};
      default: return {5'b11110, 3'($urandom_range(0, 7))};
    endcase
  endfunction

  // lead byte followed by too few continuation bytes
  task automatic queue_partial();
    int unsigned len;
    len = $urandom_range(2, 4);
    push_byte(lead_byte(len), 1'b0);
    repeat ($urandom_range(0, len - 2)) push_byte(cont_byte(), 1'b0);
  endtask

  task automatic queue_char();
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      push_byte(($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25)), 1'b0);
    end else if (kind < 45) begin
      push_byte(8'($urandom_range(0, 127)), 1'b0);
    end else if (kind < 78) begin
      // well-formed multibyte character
      len = (kind < 60) ? 2 : (kind < 70) ? 3 : 4;
      push_byte(lead_byte(len), 1'b0);
      repeat (len - 1) push_byte(cont_byte(), 1'b0);
    end else if (kind < 85) begin
      // invalid lead: stray continuation or 0xf8..0xff
      push_byte($urandom_range(0, 1) ? {2'b10, 6'($urandom_range(0, 63))}
                                     : 8'($urandom_range(248, 255)), 1'b0);
    end else if (kind < 93) begin
      queue_partial();
    end else begin
      push_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // one text of a few characters, sometimes cut inside its final character
  task automatic queue_text();
    text_item_t tail;
    repeat ($urandom_range(1, 8)) queue_char();
    if ($urandom_range(0, 3) == 0) queue_partial();
    tail = byte_feed.pop_back();
    tail.last = 1'b1;
    byte_feed.insert(byte_feed.size(), tail);
  endtask

  task automatic queue_texts(input int unsigned n_bytes);
    int unsigned start;
    start = byte_feed.size();
    while (byte_feed.size() - start < n_bytes) queue_text();
  endtask

  // wait for every byte offered and every result seen, then let silent work finish
  task automatic drain();
    @(negedge clk_i);
    while (byte_feed.size() != 0 || in_valid_i || char_expect.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic value);
    drain();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    mode_word = value;
    @(negedge clk_i);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed text, word mode from reset
    push_byte(8'h41, 1'b0);   // letters at both ends of the ranges
    push_byte(8'h7A, 1'b0);
    push_byte(8'h5B, 1'b0);   // punctuation between the letter ranges
    push_byte(8'h61, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b0);   // stray continuation as lead
    push_byte(8'hFF, 1'b0);   // invalid leads
    push_byte(8'hF8, 1'b0);
    push_byte(8'hC0, 1'b0);   // smallest two-byte lead
    push_byte(8'hBF, 1'b0);
    push_byte(8'hE0, 1'b0);   // three-byte character
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hF7, 1'b0);   // largest four-byte lead, end of text on the last byte
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b1);
    push_byte(8'hF0, 1'b0);   // cut four-byte: three single-byte results
    push_byte(8'hE2, 1'b0);
    push_byte(8'h41, 1'b1);
    push_byte(8'hC3, 1'b1);   // text ends on a lone lead
    push_byte(8'hF1, 1'b0);   // cut four-byte: lead alone, rest forms a two-byte
    push_byte(8'hC3, 1'b0);
    push_byte(8'h80, 1'b1);

    // random texts across both token modes
    write_mode(1'b0);
    queue_texts(100);
    write_mode(1'b1);
    queue_texts(100);
    write_mode(1'b0);
    queue_texts(50);
    write_mode(1'b1);
    queue_texts(50);
    drain();

    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/u8seg_pkg.sv
hdl/u8seg_core.sv
hdl/utf8_char_and_word_segmenter.sv
verif/utf8_char_and_word_segmenter_test.sv
